### hw/rtl/mfcw_pkg.sv
// Shared types and constants of the clipped-window median filter.
package mfcw_pkg;

    localparam int PIX_W     = 8;
    localparam int POS_W     = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 11;
    localparam int WIN_REG_W = 4;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    // Input word actions
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    typedef struct packed {
        logic             action;
        logic [PIX_W-1:0] pixel;
    } in_word_t;

    typedef struct packed {
        logic [PIX_W-1:0] filtered;
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
        logic             last;
    } out_word_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SETUP,
        BK_SCAN,
        BK_FINISH,
        BK_OUT
    } back_state_t;

endpackage

### hw/rtl/mfcw_front.sv
// Front end: takes words, writes the line store and issues output jobs.
module mfcw_front
    import mfcw_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_WINDOW = 11,
    localparam int RING  = MAX_WINDOW + 1,
    localparam int CW    = $clog2(MAX_WIDTH),
    localparam int RW    = $clog2(MAX_HEIGHT),
    localparam int RRW   = $clog2(RING),
    localparam int EW    = $clog2(MAX_WIDTH + 1),
    localparam int EHW   = $clog2(MAX_HEIGHT + 1),
    localparam int HMAX  = (MAX_WINDOW - 1) / 2,
    localparam int LW    = $clog2(HMAX * MAX_WIDTH + HMAX + 1),
    localparam int AW    = $clog2(RING * MAX_WIDTH),
    localparam int JW    = RW + CW + RRW + 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             restart,
    input  logic [EW-1:0]    eff_w,
    input  logic [EHW-1:0]   eff_hgt,
    input  logic [LW-1:0]    lag,
    input  logic             back_busy,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_word_t         s_data,
    output logic             wr_en,
    output logic [AW-1:0]    wr_addr,
    output logic [PIX_W-1:0] wr_data,
    input  logic             q_full,
    output logic             q_push,
    output logic [JW-1:0]    q_job
);

    localparam logic [AW-1:0]  STRIDE   = AW'(MAX_WIDTH);
    localparam logic [RRW-1:0] RING_TOP = RRW'(RING - 1);

    logic [RW-1:0]  in_row_reg, in_row_next;
    logic [CW-1:0]  in_col_reg, in_col_next;
    logic [RRW-1:0] in_ring_reg, in_ring_next;
    logic [RW-1:0]  em_row_reg, em_row_next;
    logic [CW-1:0]  em_col_reg, em_col_next;
    logic [RRW-1:0] em_ring_reg, em_ring_next;
    logic [LW-1:0]  pend_reg, pend_next;
    logic           draining_reg, draining_next;
    logic           frame_start, accept, emit;
    logic           in_col_end, in_row_end, em_col_end, em_row_end;

    assign frame_start = !draining_reg && (in_row_reg == '0) && (in_col_reg == '0);
    assign s_ready     = !q_full && !(frame_start && back_busy);
    assign accept      = s_valid && s_ready;

    assign in_col_end = (EW'(in_col_reg) == eff_w - EW'(1));
    assign in_row_end = (EHW'(in_row_reg) == eff_hgt - EHW'(1));
    assign em_col_end = (EW'(em_col_reg) == eff_w - EW'(1));
    assign em_row_end = (EHW'(em_row_reg) == eff_hgt - EHW'(1));

    assign wr_addr = AW'(in_ring_reg) * STRIDE + AW'(in_col_reg);
    assign wr_data = s_data.pixel;
    assign q_job   = {em_row_reg, em_col_reg, em_ring_reg, em_row_end && em_col_end};

    // Counter updates per accepted word; restart clears them all
    always_comb begin
        in_row_next   = in_row_reg;
        in_col_next   = in_col_reg;
        in_ring_next  = in_ring_reg;
        em_row_next   = em_row_reg;
        em_col_next   = em_col_reg;
        em_ring_next  = em_ring_reg;
        pend_next     = pend_reg;
        draining_next = draining_reg;
        wr_en         = 1'b0;
        emit          = 1'b0;
        if (restart) begin
            in_row_next   = '0;
            in_col_next   = '0;
            in_ring_next  = '0;
            em_row_next   = '0;
            em_col_next   = '0;
            em_ring_next  = '0;
            pend_next     = '0;
            draining_next = 1'b0;
        end else if (accept) begin
            if (draining_reg) begin
                emit      = 1'b1;
                pend_next = pend_reg - LW'(1);
            end else if (s_data.action == ACT_PIXEL) begin
                wr_en = 1'b1;
                emit  = (pend_reg >= lag);
                if (!emit) begin
                    pend_next = pend_reg + LW'(1);
                end
                if (in_col_end) begin
                    in_col_next  = '0;
                    in_ring_next = (in_ring_reg == RING_TOP) ? '0 : in_ring_reg + RRW'(1);
                    if (in_row_end) begin
                        in_row_next   = '0;
                        draining_next = 1'b1;
                    end else begin
                        in_row_next = in_row_reg + RW'(1);
                    end
                end else begin
                    in_col_next = in_col_reg + CW'(1);
                end
            end
            if (emit) begin
                if (em_col_end) begin
                    em_col_next  = '0;
                    em_ring_next = (em_ring_reg == RING_TOP) ? '0 : em_ring_reg + RRW'(1);
                    if (em_row_end) begin
                        em_row_next   = '0;
                        draining_next = 1'b0;
                    end else begin
                        em_row_next = em_row_reg + RW'(1);
                    end
                end else begin
                    em_col_next = em_col_reg + CW'(1);
                end
            end
        end
    end

    assign q_push = emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_ring_reg  <= '0;
            em_row_reg   <= '0;
            em_col_reg   <= '0;
            em_ring_reg  <= '0;
            pend_reg     <= '0;
            draining_reg <= 1'b0;
        end else begin
            in_row_reg   <= in_row_next;
            in_col_reg   <= in_col_next;
            in_ring_reg  <= in_ring_next;
            em_row_reg   <= em_row_next;
            em_col_reg   <= em_col_next;
            em_ring_reg  <= em_ring_next;
            pend_reg     <= pend_next;
            draining_reg <= draining_next;
        end
    end

endmodule

### hw/rtl/mfcw_jobq.sv
// Single-entry job queue between front end and median engine.
module mfcw_jobq
    import mfcw_pkg::*;
#(
    parameter int JW = 24
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  logic [JW-1:0] push_job,
    input  logic          pop,
    output logic          full,
    output logic [JW-1:0] head_job
);

    logic          valid_reg, valid_next;
    logic [JW-1:0] job_reg, job_next;

    // Pop frees the slot, push fills it
    always_comb begin
        valid_next = valid_reg;
        job_next   = job_reg;
        if (pop) begin
            valid_next = 1'b0;
        end
        if (push) begin
            valid_next = 1'b1;
            job_next   = push_job;
        end
    end

    assign full     = valid_reg;
    assign head_job = job_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        job_reg <= job_next;
    end

endmodule

### hw/rtl/mfcw_back.sv
// Median engine: line store plus bit-serial rank selection over the window.
module mfcw_back
    import mfcw_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_WINDOW = 11,
    localparam int RING  = MAX_WINDOW + 1,
    localparam int CW    = $clog2(MAX_WIDTH),
    localparam int RW    = $clog2(MAX_HEIGHT),
    localparam int RRW   = $clog2(RING),
    localparam int EW    = $clog2(MAX_WIDTH + 1),
    localparam int EHW   = $clog2(MAX_HEIGHT + 1),
    localparam int HMAX  = (MAX_WINDOW - 1) / 2,
    localparam int HW    = $clog2(HMAX + 1),
    localparam int WW    = $clog2(MAX_WINDOW + 1),
    localparam int NW    = $clog2(MAX_WINDOW * MAX_WINDOW + 1),
    localparam int AW    = $clog2(RING * MAX_WIDTH),
    localparam int JW    = RW + CW + RRW + 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [EW-1:0]    eff_w,
    input  logic [EHW-1:0]   eff_hgt,
    input  logic [HW-1:0]    eff_half,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [PIX_W-1:0] wr_data,
    input  logic             job_valid,
    input  logic [JW-1:0]    job,
    output logic             job_pop,
    output logic             busy,
    output logic             m_valid,
    input  logic             m_ready,
    output out_word_t        m_data
);

    localparam int             MEM_DEPTH = RING * MAX_WIDTH;
    localparam logic [AW-1:0]  STRIDE    = AW'(MAX_WIDTH);
    localparam logic [RRW-1:0] RING_TOP  = RRW'(RING - 1);

    back_state_t state_reg, state_next;

    logic [PIX_W-1:0] mem [MEM_DEPTH];
    logic [PIX_W-1:0] rd_data_reg;
    logic             rd_valid_reg;
    logic             rd_issue;
    logic [AW-1:0]    rd_addr;

    logic [RW-1:0]    jrow_reg, jrow_next;
    logic [CW-1:0]    jcol_reg, jcol_next;
    logic [RRW-1:0]   jring_reg, jring_next;
    logic             jlast_reg, jlast_next;
    logic [CW-1:0]    c0_reg, c0_next, c1_reg, c1_next;
    logic [RRW-1:0]   ring0_reg, ring0_next;
    logic [WW-1:0]    nrows_reg, nrows_next;
    logic [RRW-1:0]   cur_ring_reg, cur_ring_next;
    logic [CW-1:0]    cur_col_reg, cur_col_next;
    logic [WW-1:0]    row_idx_reg, row_idx_next;
    logic [2:0]       bit_reg, bit_next;
    logic [PIX_W-1:0] pa_reg, pa_next, pb_reg, pb_next;
    logic [NW-1:0]    ka_reg, ka_next, kb_reg, kb_next;
    logic [NW-1:0]    cnt_a_reg, cnt_a_next, cnt_b_reg, cnt_b_next;
    logic             mval_reg, mval_next;
    out_word_t        mdat_reg, mdat_next;

    // Window bounds, clipped to the image
    logic [EHW:0]     r_e, h_r, r0, r1, hgt_e;
    logic [EW:0]      c_e, h_c, c0, c1, w_e;
    logic [RRW-1:0]   ring_back;
    logic [WW-1:0]    nrows, ncols;
    logic [NW-1:0]    n_cells;
    logic [RRW-1:0]   ring0;

    always_comb begin
        r_e   = (EHW+1)'(jrow_reg);
        h_r   = (EHW+1)'(eff_half);
        hgt_e = (EHW+1)'(eff_hgt);
        c_e   = (EW+1)'(jcol_reg);
        h_c   = (EW+1)'(eff_half);
        w_e   = (EW+1)'(eff_w);
        r0    = (r_e >= h_r) ? r_e - h_r : '0;
        r1    = (r_e + h_r < hgt_e) ? r_e + h_r : hgt_e - (EHW+1)'(1);
        c0    = (c_e >= h_c) ? c_e - h_c : '0;
        c1    = (c_e + h_c < w_e) ? c_e + h_c : w_e - (EW+1)'(1);
        ring_back = RRW'(r_e - r0);
        nrows = WW'(r1 - r0 + (EHW+1)'(1));
        ncols = WW'(c1 - c0 + (EW+1)'(1));
        n_cells = NW'(nrows) * NW'(ncols);
        if (jring_reg >= ring_back) begin
            ring0 = jring_reg - ring_back;
        end else begin
            ring0 = RRW'({1'b0, jring_reg} + (RRW+1)'(RING) - {1'b0, ring_back});
        end
    end

    // Rank test on the word coming back from the line store
    logic [PIX_W-1:0] hi_mask;
    logic             hit_a, hit_b;
    logic [NW-1:0]    tot_a, tot_b;
    logic [PIX_W:0]   mean;

    assign hi_mask = PIX_W'(16'h01FE << bit_reg);
    assign hit_a   = rd_valid_reg && (((rd_data_reg ^ pa_reg) & hi_mask) == '0)
                     && !rd_data_reg[bit_reg];
    assign hit_b   = rd_valid_reg && (((rd_data_reg ^ pb_reg) & hi_mask) == '0)
                     && !rd_data_reg[bit_reg];
    assign tot_a   = cnt_a_reg + NW'(hit_a);
    assign tot_b   = cnt_b_reg + NW'(hit_b);
    assign mean    = ({1'b0, pa_reg} + {1'b0, pb_reg}) >> 1;

    assign rd_addr = AW'(cur_ring_reg) * STRIDE + AW'(cur_col_reg);

    // Sequencer: next state and datapath
    always_comb begin
        state_next    = state_reg;
        jrow_next     = jrow_reg;
        jcol_next     = jcol_reg;
        jring_next    = jring_reg;
        jlast_next    = jlast_reg;
        c0_next       = c0_reg;
        c1_next       = c1_reg;
        ring0_next    = ring0_reg;
        nrows_next    = nrows_reg;
        cur_ring_next = cur_ring_reg;
        cur_col_next  = cur_col_reg;
        row_idx_next  = row_idx_reg;
        bit_next      = bit_reg;
        pa_next       = pa_reg;
        pb_next       = pb_reg;
        ka_next       = ka_reg;
        kb_next       = kb_reg;
        cnt_a_next    = tot_a;
        cnt_b_next    = tot_b;
        mval_next     = mval_reg && !m_ready;
        mdat_next     = mdat_reg;
        job_pop       = 1'b0;
        rd_issue      = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                if (job_valid) begin
                    job_pop    = 1'b1;
                    {jrow_next, jcol_next, jring_next, jlast_next} = job;
                    state_next = BK_SETUP;
                end
            end
            BK_SETUP: begin
                c0_next       = CW'(c0);
                c1_next       = CW'(c1);
                ring0_next    = ring0;
                nrows_next    = nrows;
                cur_ring_next = ring0;
                cur_col_next  = CW'(c0);
                row_idx_next  = '0;
                bit_next      = 3'd7;
                pa_next       = '0;
                pb_next       = '0;
                ka_next       = (n_cells - NW'(1)) >> 1;
                kb_next       = n_cells >> 1;
                cnt_a_next    = '0;
                cnt_b_next    = '0;
                state_next    = BK_SCAN;
            end
            BK_SCAN: begin
                rd_issue = 1'b1;
                if (cur_col_reg == c1_reg) begin
                    cur_col_next = c0_reg;
                    if (row_idx_reg == nrows_reg - WW'(1)) begin
                        state_next = BK_FINISH;
                    end else begin
                        row_idx_next  = row_idx_reg + WW'(1);
                        cur_ring_next = (cur_ring_reg == RING_TOP) ? '0
                                        : cur_ring_reg + RRW'(1);
                    end
                end else begin
                    cur_col_next = cur_col_reg + CW'(1);
                end
            end
            BK_FINISH: begin
                // Settle one bit of each of the two middle ranks
                if (ka_reg < tot_a) begin
                    pa_next[bit_reg] = 1'b0;
                end else begin
                    pa_next[bit_reg] = 1'b1;
                    ka_next = ka_reg - tot_a;
                end
                if (kb_reg < tot_b) begin
                    pb_next[bit_reg] = 1'b0;
                end else begin
                    pb_next[bit_reg] = 1'b1;
                    kb_next = kb_reg - tot_b;
                end
                cnt_a_next    = '0;
                cnt_b_next    = '0;
                cur_ring_next = ring0_reg;
                cur_col_next  = c0_reg;
                row_idx_next  = '0;
                if (bit_reg == 3'd0) begin
                    state_next = BK_OUT;
                end else begin
                    bit_next   = bit_reg - 3'd1;
                    state_next = BK_SCAN;
                end
            end
            BK_OUT: begin
                if (!mval_reg || m_ready) begin
                    mval_next          = 1'b1;
                    mdat_next.filtered = PIX_W'(mean);
                    mdat_next.out_row  = POS_W'(jrow_reg);
                    mdat_next.out_col  = POS_W'(jcol_reg);
                    mdat_next.last     = jlast_reg;
                    state_next         = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign busy    = (state_reg != BK_IDLE);
    assign m_valid = mval_reg;
    assign m_data  = mdat_reg;

    // Line store: one write port from the front, one read port here
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_issue) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BK_IDLE;
            mval_reg     <= 1'b0;
            rd_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mval_reg     <= mval_next;
            rd_valid_reg <= rd_issue;
        end
    end

    always_ff @(posedge aclk) begin
        jrow_reg     <= jrow_next;
        jcol_reg     <= jcol_next;
        jring_reg    <= jring_next;
        jlast_reg    <= jlast_next;
        c0_reg       <= c0_next;
        c1_reg       <= c1_next;
        ring0_reg    <= ring0_next;
        nrows_reg    <= nrows_next;
        cur_ring_reg <= cur_ring_next;
        cur_col_reg  <= cur_col_next;
        row_idx_reg  <= row_idx_next;
        bit_reg      <= bit_next;
        pa_reg       <= pa_next;
        pb_reg       <= pb_next;
        ka_reg       <= ka_next;
        kb_reg       <= kb_next;
        cnt_a_reg    <= cnt_a_next;
        cnt_b_reg    <= cnt_b_next;
        mdat_reg     <= mdat_next;
    end

endmodule

### hw/rtl/median_filter_clipped_window.sv
// Top level of the streaming median filter with a clipped square window.
//
// Input words (s_*) carry raster pixels or drain ticks; output words (m_*)
// carry the median, its row and column and an end-of-frame flag. Both use
// valid/ready. Registers (window size, width, height) are written through
// cfg_we/cfg_index/cfg_wdata; a write to any of them restarts the frame.
// Each pixel is written to a ring of MAX_WINDOW+1 lines at once. Once the
// input is half a window ahead, each pixel queues one output job; after the
// last pixel every word drains one pending output.
// A job takes 8 passes over the clipped window (up to 121 pixels): each
// pass reads every window pixel through the single line-store read port
// and settles one bit of the two middle ranks. One job can wait in the queue
// while the engine works; the front takes words only while that slot is
// empty, and the first pixel of a frame waits until the engine is idle.
// Reset clears counters and valids; the line store is not cleared. A
// stalled receiver holds the result register and the engine behind it.
module median_filter_clipped_window
    import mfcw_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_WINDOW = 11,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_word_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_word_t            m_data
);

    localparam int RING = MAX_WINDOW + 1;
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int RRW  = $clog2(RING);
    localparam int EW   = $clog2(MAX_WIDTH + 1);
    localparam int EHW  = $clog2(MAX_HEIGHT + 1);
    localparam int HMAX = (MAX_WINDOW - 1) / 2;
    localparam int HW   = $clog2(HMAX + 1);
    localparam int LW   = $clog2(HMAX * MAX_WIDTH + HMAX + 1);
    localparam int AW   = $clog2(RING * MAX_WIDTH);
    localparam int JW   = RW + CW + RRW + 1;

    logic [WIN_REG_W-1:0] window_size_reg, window_size_next;
    logic [CFG_DAT_W-1:0] image_width_reg, image_width_next;
    logic [CFG_DAT_W-1:0] image_height_reg, image_height_next;
    logic                 restart;

    // Register writes
    always_comb begin
        window_size_next  = window_size_reg;
        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        restart           = 1'b0;
        if (cfg_we) begin
            case (cfg_index)
                CFG_WINDOW_SIZE: begin
                    window_size_next = WIN_REG_W'(cfg_wdata);
                    restart          = 1'b1;
                end
                CFG_IMAGE_WIDTH: begin
                    image_width_next = cfg_wdata;
                    restart          = 1'b1;
                end
                CFG_IMAGE_HEIGHT: begin
                    image_height_next = cfg_wdata;
                    restart           = 1'b1;
                end
                default: begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_size_reg  <= WIN_REG_W'(3);
            image_width_reg  <= CFG_DAT_W'(640);
            image_height_reg <= CFG_DAT_W'(480);
        end else begin
            window_size_reg  <= window_size_next;
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
        end
    end

    // Effective geometry: zero acts as one, large values saturate
    logic [EW-1:0]  eff_w;
    logic [EHW-1:0] eff_hgt;
    logic [HW-1:0]  eff_half;
    logic [LW-1:0]  lag;

    always_comb begin
        if (image_width_reg == '0) begin
            eff_w = EW'(1);
        end else if (int'(image_width_reg) > MAX_WIDTH) begin
            eff_w = EW'(MAX_WIDTH);
        end else begin
            eff_w = EW'(image_width_reg);
        end
        if (image_height_reg == '0) begin
            eff_hgt = EHW'(1);
        end else if (int'(image_height_reg) > MAX_HEIGHT) begin
            eff_hgt = EHW'(MAX_HEIGHT);
        end else begin
            eff_hgt = EHW'(image_height_reg);
        end
        if (int'(window_size_reg >> 1) > HMAX) begin
            eff_half = HW'(HMAX);
        end else begin
            eff_half = HW'(window_size_reg >> 1);
        end
        lag = LW'(eff_half) * LW'(eff_w) + LW'(eff_half);
    end

    logic             back_busy, q_full, q_push, q_pop;
    logic [JW-1:0]    q_in, q_head;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [PIX_W-1:0] wr_data;

    mfcw_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .restart   (restart),
        .eff_w     (eff_w),
        .eff_hgt   (eff_hgt),
        .lag       (lag),
        .back_busy (back_busy),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (q_in)
    );

    mfcw_jobq #(
        .JW (JW)
    ) u_jobq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_in),
        .pop      (q_pop),
        .full     (q_full),
        .head_job (q_head)
    );

    mfcw_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .eff_w     (eff_w),
        .eff_hgt   (eff_hgt),
        .eff_half  (eff_half),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .job_valid (q_full),
        .job       (q_head),
        .job_pop   (q_pop),
        .busy      (back_busy),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // A job is queued only into an empty slot
    a_push_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("job queued while queue full");

    // The engine takes a job only when one waits and it is idle
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_full && !back_busy)
        else $error("job taken from empty queue or by busy engine");

    // No word is taken while the engine is working and a job waits in the queue
    a_frame_gate: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && back_busy) |-> !(q_full))
        else $error("word accepted with a job pending");

endmodule

### dv/median_filter_clipped_window_test.sv
// Testbench for the clipped-window median filter: a frame predictor, stalls and frame checks.
module median_filter_clipped_window_test;
    import mfcw_pkg::*;

    localparam int MAX_W     = 1024;
    localparam int MAX_H     = 1024;
    localparam int MAX_WIN   = 11;
    localparam int RING      = MAX_WIN + 1;
    localparam int CELLS     = MAX_WIN * MAX_WIN;
    // a wait that covers one job of the largest window, with margin
    localparam int JOB_HOLD  = 1100;
    localparam int STALL_MAX = 50000;

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_wdata = '0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    in_word_t  s_data    = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    out_word_t m_data;

    median_filter_clipped_window u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Filter predictor state
    logic [7:0]  pix_store [RING*MAX_W];
    logic [3:0]  win_reg;
    logic [10:0] width_reg, height_reg;
    int          in_row, in_col, emit_row, emit_col;
    bit          flushing;

    out_word_t   medians_due[$];
    int          errors, words_sent, medians_seen, frames_run, prints;
    int          idle_pct, stall_pct;

    function automatic int eff_width();
        if (width_reg == 0) return 1;
        return (width_reg > MAX_W) ? MAX_W : int'(width_reg);
    endfunction

    function automatic int eff_height();
        if (height_reg == 0) return 1;
        return (height_reg > MAX_H) ? MAX_H : int'(height_reg);
    endfunction

    function automatic int eff_half();
        int hw;
        hw = win_reg / 2;
        return (hw > (MAX_WIN - 1) / 2) ? (MAX_WIN - 1) / 2 : hw;
    endfunction

    function automatic void restart_frame();
        in_row = 0; in_col = 0; emit_row = 0; emit_col = 0;
        flushing = 1'b0;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        case (idx)
            CFG_WINDOW_SIZE:  win_reg    = val[3:0];
            CFG_IMAGE_WIDTH:  width_reg  = val;
            CFG_IMAGE_HEIGHT: height_reg = val;
            default: return;
        endcase
        restart_frame();
    endfunction

    // Median of the clipped window at the output position, then step it on
    function automatic out_word_t emit_median();
        int w, hg, hw, r0, r1, c0, c1, n, k, med;
        logic [7:0] v [CELLS];
        logic [7:0] x;
        out_word_t res;
        w = eff_width(); hg = eff_height(); hw = eff_half();
        r0 = (emit_row >= hw) ? emit_row - hw : 0;
        r1 = (emit_row + hw < hg) ? emit_row + hw : hg - 1;
        c0 = (emit_col >= hw) ? emit_col - hw : 0;
        c1 = (emit_col + hw < w) ? emit_col + hw : w - 1;
        n = 0;
        for (int i = r0; i <= r1; i++) begin
            for (int j = c0; j <= c1; j++) begin
                x = pix_store[(i % RING) * MAX_W + (j % MAX_W)];
                k = n;
                while (k > 0 && v[k-1] > x) begin
                    v[k] = v[k-1];
                    k--;
                end
                v[k] = x;
                n++;
            end
        end
        if (n == 0) med = 0;
        else if (n % 2 == 1) med = v[n/2];
        else med = (int'(v[n/2-1]) + int'(v[n/2])) / 2;
        res.filtered = med[7:0];
        res.out_row  = emit_row[9:0];
        res.out_col  = emit_col[9:0];
        res.last     = (emit_row == hg - 1 && emit_col == w - 1);
        emit_col++;
        if (emit_col >= w) begin
            emit_col = 0;
            emit_row++;
            if (emit_row >= hg) begin
                emit_row = 0;
                flushing = 1'b0;
            end
        end
        return res;
    endfunction

    // Work out what one accepted input word produces
    function automatic void predict_word(in_word_t wd, output bit got, output out_word_t res);
        int w, hg, hw, in_pos, emit_pos, lag;
        got = 1'b0;
        res = '0;
        if (flushing) begin
            res = emit_median();
            got = 1'b1;
            return;
        end
        if (wd.action == ACT_DRAIN) return;
        w = eff_width(); hg = eff_height(); hw = eff_half();
        if (in_row >= hg || in_col >= w) restart_frame();
        pix_store[(in_row % RING) * MAX_W + (in_col % MAX_W)] = wd.pixel;
        in_pos   = in_row * w + in_col;
        emit_pos = emit_row * w + emit_col;
        lag      = hw * w + hw;
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
            if (in_row >= hg) begin
                in_row = 0;
                flushing = 1'b1;
            end
        end
        if (in_pos >= emit_pos && in_pos - emit_pos >= lag) begin
            res = emit_median();
            got = 1'b1;
        end
    endfunction

    task automatic report_mismatch(string what);
        errors++;
        if (prints < 30) begin
            prints++;
            $display("mismatch: %s", what);
        end
    endtask

    // Result checker
    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            medians_seen++;
            if (medians_due.size() == 0) begin
                report_mismatch($sformatf("unexpected word row %0d col %0d",
                                          m_data.out_row, m_data.out_col));
            end else begin
                want = medians_due.pop_front();
                if (m_data.filtered !== want.filtered)
                    report_mismatch($sformatf("filtered %0d, want %0d at (%0d,%0d)",
                        m_data.filtered, want.filtered, want.out_row, want.out_col));
                if (m_data.out_row !== want.out_row)
                    report_mismatch($sformatf("out_row %0d, want %0d",
                        m_data.out_row, want.out_row));
                if (m_data.out_col !== want.out_col)
                    report_mismatch($sformatf("out_col %0d, want %0d",
                        m_data.out_col, want.out_col));
                if (m_data.last !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b at (%0d,%0d)",
                        m_data.last, want.last, want.out_row, want.out_col));
            end
        end
    end

    // Receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        int quiet;
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) quiet = 0;
        else quiet++;
        if (quiet >= STALL_MAX) begin
            $display("watchdog expired with %0d words still due", medians_due.size());
            $display("[median_filter_clipped_window] ERROR");
            $finish;
        end
    end

    // Send one word, with an optional gap before it
    task automatic send_word(logic act, logic [7:0] pix);
        int gap;
        bit got;
        out_word_t res;
        in_word_t wd;
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        wd.action = act;
        wd.pixel  = pix;
        s_valid <= 1'b1;
        s_data  <= wd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_word(wd, got, res);
        if (got) medians_due.push_back(res);
        words_sent++;
    endtask

    // Wait for every due word, then for the engine to go quiet
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (medians_due.size() != 0) @(posedge aclk);
        repeat (JOB_HOLD) @(posedge aclk);
    endtask

    task automatic configure(int ws, int w, int h);
        logic [CFG_DAT_W-1:0] vals [3];
        logic [CFG_IDX_W-1:0] idx  [3];
        wait_drained();
        vals[0] = CFG_DAT_W'(ws); vals[1] = CFG_DAT_W'(w); vals[2] = CFG_DAT_W'(h);
        idx[0] = CFG_WINDOW_SIZE; idx[1] = CFG_IMAGE_WIDTH; idx[2] = CFG_IMAGE_HEIGHT;
        for (int i = 0; i < 3; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
            apply_reg(idx[i], vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] pick_pixel(bit edgy);
        logic [7:0] corner [6] = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd127, 8'd128};
        if (edgy) return corner[$urandom_range(5)];
        return 8'($urandom_range(255));
    endfunction

    // One frame: pixels with optional stray drains, then the flush.
    // cut_at >= 0 stops the frame early; pause_at holds the sender until drained.
    task automatic run_frame(int ws, int w, int h, int noise_pct, bit edgy,
                             int cut_at, int pause_at);
        int pixels;
        configure(ws, w, h);
        frames_run++;
        pixels = eff_width() * eff_height();
        for (int i = 0; i < pixels; i++) begin
            if (i == cut_at) return;
            if (i == pause_at) begin
                s_valid <= 1'b0;
                @(posedge aclk);
                while (medians_due.size() != 0) @(posedge aclk);
            end
            if ($urandom_range(99) < noise_pct)
                send_word(ACT_DRAIN, 8'($urandom_range(255)));
            send_word(ACT_PIXEL, pick_pixel(edgy));
        end
        // pixels sent while flushing count as drain ticks
        while (flushing) begin
            if ($urandom_range(99) < 30) send_word(ACT_PIXEL, 8'($urandom_range(255)));
            else send_word(ACT_DRAIN, 8'($urandom_range(255)));
        end
        // nothing left to flush
        send_word(ACT_DRAIN, 8'd0);
    endtask

    task automatic test_directed();
        idle_pct = 0; stall_pct = 0;
        // early drain, extreme pixels, flush of a small frame
        configure(3, 3, 2);
        frames_run++;
        send_word(ACT_DRAIN, 8'hff);
        send_word(ACT_PIXEL, 8'd0);
        send_word(ACT_PIXEL, 8'd255);
        send_word(ACT_PIXEL, 8'd0);
        send_word(ACT_DRAIN, 8'h00);
        send_word(ACT_PIXEL, 8'd255);
        send_word(ACT_PIXEL, 8'd255);
        send_word(ACT_PIXEL, 8'd1);
        send_word(ACT_PIXEL, 8'd77);
        while (flushing) send_word(ACT_DRAIN, 8'd0);
        send_word(ACT_DRAIN, 8'd0);
        // even and out-of-range window sizes, zero-sized image
        run_frame(0, 4, 3, 0, 1, -1, -1);
        run_frame(4, 4, 4, 0, 1, -1, -1);
        run_frame(15, 12, 12, 0, 1, -1, -1);
        run_frame(3, 0, 0, 0, 1, -1, -1);
    endtask

    task automatic test_size_extremes();
        idle_pct = 13; stall_pct = 13;
        // widest row (width saturates) and tallest column, first pixels only;
        // then the largest window over a full frame, and a saturated window and height
        run_frame(1, 2047, 1, 5, 0, 100, -1);
        run_frame(3, 1, 1024, 5, 0, 100, -1);
        run_frame(11, 11, 11, 5, 1, -1, -1);
        run_frame(12, 6, 2047, 0, 0, 40, -1);
    endtask

    task automatic test_random_frames();
        int pct_idle [4] = '{0, 45, 0, 13};
        int pct_stall[4] = '{0, 0, 45, 13};
        int start, goal, ws, w, h, cut, pause;
        bit paused;
        paused = 1'b0;
        start = words_sent;
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = pct_idle[ph];
            stall_pct = pct_stall[ph];
            goal = start + 550 * (ph + 1) / 4;
            while (words_sent < goal) begin
                ws = ($urandom_range(9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 5);
                w  = ($urandom_range(19) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                h  = $urandom_range(1, 10);
                cut   = ($urandom_range(11) == 0) ? $urandom_range(0, w * h - 1) : -1;
                pause = -1;
                if (!paused && ph == 3 && w * h > 4) begin
                    pause = w * h / 2;
                    paused = 1'b1;
                end
                run_frame(ws, w, h, $urandom_range(0, 1) ? 8 : 0,
                          $urandom_range(3) == 0, cut, pause);
            end
        end
    endtask

    initial begin
        win_reg = 4'd3; width_reg = 11'd640; height_reg = 11'd480;
        restart_frame();
        foreach (pix_store[i]) pix_store[i] = '0;
        errors = 0; words_sent = 0; medians_seen = 0; frames_run = 0; prints = 0;
        idle_pct = 0; stall_pct = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_size_extremes();
        test_random_frames();

        s_valid <= 1'b0;
        @(posedge aclk);
        while (medians_due.size() != 0) @(posedge aclk);
        repeat (JOB_HOLD) @(posedge aclk);

        $display("covered %0d frames, %0d input words and %0d median words", frames_run,
                 words_sent, medians_seen);
        $display("windows 0..15, sizes 0 to saturation, stray drains, aborts and stalls");
        if (errors == 0) begin
            $display("[median_filter_clipped_window] OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("[median_filter_clipped_window] ERROR");
        end
        $finish;
    end

endmodule

### median_filter_clipped_window.f
hw/rtl/mfcw_pkg.sv
hw/rtl/mfcw_front.sv
hw/rtl/mfcw_jobq.sv
hw/rtl/mfcw_back.sv
hw/rtl/median_filter_clipped_window.sv
dv/median_filter_clipped_window_test.sv
